// ----- rtl/tlr_pkg.sv -----
// Shared types and constants for the thick line rasterizer.
// Used by every module of the block; depends on nothing else.
package tlr_pkg;

  localparam int COORD_BITS_DEF    = 13;
  localparam int MAX_THICKNESS_DEF = 63;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int IN_COORD_W = 12;
  localparam int DELTA_W    = IN_COORD_W + 1;
  localparam int MAG_W      = IN_COORD_W;
  localparam int THICK_IN_W = 6;
  localparam int COLOUR_W   = 8;
  localparam int STRIDE_W   = 13;
  localparam int OFFSET_W   = 27;
  // Four bytes per pixel.
  localparam int PIX_SHIFT  = 2;
  // Error sums grow by at most |dx|+|dy| per step over at most 4095 steps.
  localparam int ERR_W      = 28;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(640);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // One classified command as it sits in the queue.
  typedef struct packed {
    cmd_t                          cmd;
    logic signed [IN_COORD_W-1:0]  start_x;
    logic signed [IN_COORD_W-1:0]  start_y;
    logic signed [DELTA_W-1:0]     dx;
    logic signed [DELTA_W-1:0]     dy;
    logic        [MAG_W-1:0]       adx;
    logic        [MAG_W-1:0]       ady;
    logic        [MAG_W-1:0]       steps;
    logic                          along_x;
    logic        [THICK_IN_W-1:0]  thickness;
    logic        [COLOUR_W-1:0]    red;
    logic        [COLOUR_W-1:0]    green;
    logic        [COLOUR_W-1:0]    blue;
  } line_cmd_t;

endpackage

// ----- rtl/tlr_front.sv -----
// Front end of the thick line rasterizer: classifies each input beat.
// Computes the deltas, magnitudes, line length and shift axis. Uses tlr_pkg.
module tlr_front import tlr_pkg::*; (
  input  logic                          in_command,
  input  logic signed [IN_COORD_W-1:0]  in_start_x,
  input  logic signed [IN_COORD_W-1:0]  in_start_y,
  input  logic signed [IN_COORD_W-1:0]  in_end_x,
  input  logic signed [IN_COORD_W-1:0]  in_end_y,
  input  logic        [COLOUR_W-1:0]    in_red,
  input  logic        [COLOUR_W-1:0]    in_green,
  input  logic        [COLOUR_W-1:0]    in_blue,
  input  logic        [THICK_IN_W-1:0]  in_thickness,
  output line_cmd_t                     cmd_o
);

  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic        [DELTA_W-1:0] adx_full;
  logic        [DELTA_W-1:0] ady_full;
  logic        [MAG_W-1:0]   adx;
  logic        [MAG_W-1:0]   ady;

  assign dx = DELTA_W'(in_end_x) - DELTA_W'(in_start_x);
  assign dy = DELTA_W'(in_end_y) - DELTA_W'(in_start_y);

  assign adx_full = dx[DELTA_W-1] ? -dx : dx;
  assign ady_full = dy[DELTA_W-1] ? -dy : dy;
  assign adx      = adx_full[MAG_W-1:0];
  assign ady      = ady_full[MAG_W-1:0];

  always_comb begin
    cmd_o.cmd       = cmd_t'(in_command);
    cmd_o.start_x   = in_start_x;
    cmd_o.start_y   = in_start_y;
    cmd_o.dx        = dx;
    cmd_o.dy        = dy;
    cmd_o.adx       = adx;
    cmd_o.ady       = ady;
    cmd_o.steps     = (adx > ady) ? adx : ady;
    cmd_o.along_x   = adx < ady;
    cmd_o.thickness = in_thickness;
    cmd_o.red       = in_red;
    cmd_o.green     = in_green;
    cmd_o.blue      = in_blue;
  end

endmodule

// ----- rtl/tlr_fifo.sv -----
// Short command queue between the front end and the line walker.
// Register based, one push and one pop per cycle. Uses tlr_pkg for defaults.
module tlr_fifo import tlr_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/tlr_back.sv -----
// Line walker of the thick line rasterizer: error-sum stepping, line copies.
// Takes classified commands from the queue and registers at most one pixel
// per beat. Uses tlr_pkg.
module tlr_back import tlr_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int MAX_THICKNESS = MAX_THICKNESS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  line_cmd_t                    q_data,
  output logic                         q_pop,
  input  logic                         p_ready,
  output logic                         p_valid,
  output logic signed [COORD_BITS-1:0] p_x,
  output logic signed [COORD_BITS-1:0] p_y,
  output logic        [COLOUR_W-1:0]   p_red,
  output logic        [COLOUR_W-1:0]   p_green,
  output logic        [COLOUR_W-1:0]   p_blue,
  output logic                         p_last
);

  localparam int CW    = COORD_BITS;
  localparam int TW    = $clog2(MAX_THICKNESS + 1);
  localparam int SAT_W = (TW > THICK_IN_W) ? TW : THICK_IN_W;

  // Line state.
  logic                         busy_r, busy_nxt;
  logic signed [CW-1:0]         cur_x_r, cur_x_nxt;
  logic signed [CW-1:0]         cur_y_r, cur_y_nxt;
  logic signed [ERR_W-1:0]      xerr_r, xerr_nxt;
  logic signed [ERR_W-1:0]      yerr_r, yerr_nxt;
  logic signed [IN_COORD_W-1:0] x0_r, x0_nxt;
  logic signed [IN_COORD_W-1:0] y0_r, y0_nxt;
  logic signed [DELTA_W-1:0]    dx_r, dx_nxt;
  logic signed [DELTA_W-1:0]    dy_r, dy_nxt;
  logic        [MAG_W-1:0]      adx_r, adx_nxt;
  logic        [MAG_W-1:0]      ady_r, ady_nxt;
  logic        [MAG_W-1:0]      len_r, len_nxt;
  logic        [MAG_W-1:0]      steps_r, steps_nxt;
  logic                         along_x_r, along_x_nxt;
  logic        [TW-1:0]         thick_r, thick_nxt;
  logic        [TW-1:0]         idx_r, idx_nxt;
  logic        [COLOUR_W-1:0]   red_r, red_nxt;
  logic        [COLOUR_W-1:0]   green_r, green_nxt;
  logic        [COLOUR_W-1:0]   blue_r, blue_nxt;

  // Pixel register.
  logic                         p_valid_r, p_valid_nxt;
  logic signed [CW-1:0]         p_x_r;
  logic signed [CW-1:0]         p_y_r;
  logic        [COLOUR_W-1:0]   p_red_r;
  logic        [COLOUR_W-1:0]   p_green_r;
  logic        [COLOUR_W-1:0]   p_blue_r;
  logic                         p_last_r;

  logic                         emit;
  logic                         last;

  // Thickness saturation for a start command.
  logic [SAT_W-1:0]             thick_ext;
  logic [TW-1:0]                thick_sat;

  // Walk terms.
  logic                         sx_pos, sy_pos;
  logic signed [ERR_W-1:0]      xs, ys;
  logic        [ERR_W-1:0]      xs_mag, ys_mag;
  logic                         x_go, y_go;
  logic signed [ERR_W-1:0]      xerr_walk, yerr_walk;
  logic signed [CW-1:0]         x_step, y_step;

  // Origin of the next parallel copy.
  logic [TW-1:0]                k_next;
  logic [TW-1:0]                half;
  logic signed [TW:0]           amt;
  logic signed [TW:0]           shift_amt;
  logic                         shift_neg;
  logic signed [CW-1:0]         off_x, off_y;
  logic [TW:0]                  line_cnt;

  assign thick_ext = SAT_W'(q_data.thickness);
  assign thick_sat = (thick_ext > SAT_W'(MAX_THICKNESS)) ? TW'(MAX_THICKNESS)
                                                         : TW'(thick_ext);

  assign sx_pos = !dx_r[DELTA_W-1] && (dx_r != '0);
  assign sy_pos = !dy_r[DELTA_W-1] && (dy_r != '0);
  assign x_step = sx_pos ? CW'(1) : {CW{1'b1}};
  assign y_step = sy_pos ? CW'(1) : {CW{1'b1}};

  assign xs     = xerr_r + ERR_W'(dx_r);
  assign ys     = yerr_r + ERR_W'(dy_r);
  assign xs_mag = xs[ERR_W-1] ? -xs : xs;
  assign ys_mag = ys[ERR_W-1] ? -ys : ys;
  assign x_go   = {xs_mag, 1'b0} > (ERR_W + 1)'(ady_r);
  assign y_go   = {ys_mag, 1'b0} > (ERR_W + 1)'(adx_r);

  assign xerr_walk = !x_go ? xs : (sx_pos ? xs - ERR_W'(ady_r) : xs + ERR_W'(ady_r));
  assign yerr_walk = !y_go ? ys : (sy_pos ? ys - ERR_W'(adx_r) : ys + ERR_W'(adx_r));

  // Copies go +1..T/2 first, then -1..(T-1)/2, along the minor axis.
  assign k_next    = idx_r + 1'b1;
  assign half      = thick_r >> 1;
  assign amt       = (k_next <= half) ? $signed({1'b0, k_next})
                                      : -$signed({1'b0, k_next - half});
  assign shift_neg = along_x_r ? !sx_pos : !sy_pos;
  assign shift_amt = shift_neg ? -amt : amt;
  assign off_x     = along_x_r ? CW'(shift_amt) : '0;
  assign off_y     = along_x_r ? '0 : CW'(shift_amt);

  assign line_cnt  = (thick_nxt == '0) ? (TW + 1)'(1) : {1'b0, thick_nxt};
  assign last      = (steps_nxt == '0) && (({1'b0, idx_nxt} + 1'b1) >= line_cnt);

  assign q_pop     = q_valid && p_ready;

  always_comb begin
    busy_nxt    = busy_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    xerr_nxt    = xerr_r;
    yerr_nxt    = yerr_r;
    x0_nxt      = x0_r;
    y0_nxt      = y0_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    adx_nxt     = adx_r;
    ady_nxt     = ady_r;
    len_nxt     = len_r;
    steps_nxt   = steps_r;
    along_x_nxt = along_x_r;
    thick_nxt   = thick_r;
    idx_nxt     = idx_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    blue_nxt    = blue_r;
    emit        = 1'b0;
    if (q_pop) begin
      if (q_data.cmd == CMD_START) begin
        // A start drops whatever line is running.
        x0_nxt      = q_data.start_x;
        y0_nxt      = q_data.start_y;
        dx_nxt      = q_data.dx;
        dy_nxt      = q_data.dy;
        adx_nxt     = q_data.adx;
        ady_nxt     = q_data.ady;
        len_nxt     = q_data.steps;
        steps_nxt   = q_data.steps;
        along_x_nxt = q_data.along_x;
        thick_nxt   = thick_sat;
        idx_nxt     = '0;
        red_nxt     = q_data.red;
        green_nxt   = q_data.green;
        blue_nxt    = q_data.blue;
        cur_x_nxt   = CW'(q_data.start_x);
        cur_y_nxt   = CW'(q_data.start_y);
        xerr_nxt    = '0;
        yerr_nxt    = '0;
        emit        = 1'b1;
      end else if (busy_r) begin
        if (steps_r != '0) begin
          cur_x_nxt = x_go ? cur_x_r + x_step : cur_x_r;
          cur_y_nxt = y_go ? cur_y_r + y_step : cur_y_r;
          xerr_nxt  = xerr_walk;
          yerr_nxt  = yerr_walk;
          steps_nxt = steps_r - 1'b1;
        end else begin
          idx_nxt   = k_next;
          cur_x_nxt = CW'(x0_r) + off_x;
          cur_y_nxt = CW'(y0_r) + off_y;
          xerr_nxt  = '0;
          yerr_nxt  = '0;
          steps_nxt = len_r;
        end
        emit = 1'b1;
      end
    end
    if (emit) begin
      busy_nxt = !last;
    end
  end

  assign p_valid_nxt = emit ? 1'b1 : (p_ready ? 1'b0 : p_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    xerr_r    <= xerr_nxt;
    yerr_r    <= yerr_nxt;
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    len_r     <= len_nxt;
    steps_r   <= steps_nxt;
    along_x_r <= along_x_nxt;
    thick_r   <= thick_nxt;
    idx_r     <= idx_nxt;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
    if (emit) begin
      p_x_r     <= cur_x_nxt;
      p_y_r     <= cur_y_nxt;
      p_red_r   <= red_nxt;
      p_green_r <= green_nxt;
      p_blue_r  <= blue_nxt;
      p_last_r  <= last;
    end
  end

  assign p_valid = p_valid_r;
  assign p_x     = p_x_r;
  assign p_y     = p_y_r;
  assign p_red   = p_red_r;
  assign p_green = p_green_r;
  assign p_blue  = p_blue_r;
  assign p_last  = p_last_r;

endmodule

// ----- rtl/tlr_emit.sv -----
// Output stage of the thick line rasterizer: byte offset and result register.
// Holds the line stride register and multiplies y by it. Uses tlr_pkg.
module tlr_emit import tlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_write,
  input  logic        [STRIDE_W-1:0]   cfg_line_stride,
  input  logic                         p_valid,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic        [COLOUR_W-1:0]   p_red,
  input  logic        [COLOUR_W-1:0]   p_green,
  input  logic        [COLOUR_W-1:0]   p_blue,
  input  logic                         p_last,
  output logic                         p_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic signed [OFFSET_W-1:0]   out_byte_offset,
  output logic        [COLOUR_W-1:0]   out_red,
  output logic        [COLOUR_W-1:0]   out_green,
  output logic        [COLOUR_W-1:0]   out_blue,
  output logic                         out_last_pixel
);

  localparam int CW    = COORD_BITS;
  localparam int LIN_W = OFFSET_W - PIX_SHIFT;
  localparam int PW    = (CW + STRIDE_W + 1 > LIN_W) ? CW + STRIDE_W + 1 : LIN_W;

  logic [STRIDE_W-1:0]        stride_r, stride_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [CW-1:0]       pixel_x_r, pixel_y_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic [COLOUR_W-1:0]        red_r, green_r, blue_r;
  logic                       last_r;
  logic                       advance;
  logic [PW-1:0]              prod;
  logic [PW-1:0]              lin;

  // Low bits of the product are the same whether the operands are taken
  // as signed or unsigned once both are extended to the full width.
  assign prod = PW'(p_y) * PW'({1'b0, stride_r});
  assign lin  = prod + PW'(p_x);

  assign advance       = !out_valid_r || !out_stall;
  assign p_ready       = advance;
  assign out_valid_nxt = advance ? p_valid : out_valid_r;
  assign stride_nxt    = cfg_write ? cfg_line_stride : stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r    <= STRIDE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      stride_r    <= stride_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p_valid) begin
      pixel_x_r <= p_x;
      pixel_y_r <= p_y;
      offset_r  <= {lin[LIN_W-1:0], {PIX_SHIFT{1'b0}}};
      red_r     <= p_red;
      green_r   <= p_green;
      blue_r    <= p_blue;
      last_r    <= p_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pixel_x_r;
  assign out_pixel_y     = pixel_y_r;
  assign out_byte_offset = offset_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_last_pixel  = last_r;

endmodule

// ----- rtl/thick_line_rasterizer_top.sv -----
// Thick line rasterizer, top level: pixel generator for a 32-bit frame buffer.
// A start beat loads a line and gives its first pixel; each step beat gives
// the next pixel of the base line and its parallel copies, in order.
// Channels:
//   in_*  : command beats (start or step), valid/stall, taken when
//           in_valid is high and in_stall is low.
//   out_* : pixel beats (x, y, byte offset, colour, last flag), valid/stall.
//   cfg_* : line stride write, valid/ready; cfg_ready is always high.
// A command passes through the queue, the pixel register and the output
// register before its pixel appears. Throughput: one command per cycle
// when unstalled; the walker updates error sums and position per pixel.
// A step beat while no line is active is consumed and gives no pixel.
// When out_stall is held, the output beat holds, the pixel register behind
// it fills, then the command queue (QUEUE_DEPTH beats) fills and in_stall
// rises. Reset is synchronous: the queue empties, no line is active, no
// output beat is valid and the stride returns to 640.
// Depends on tlr_pkg, tlr_front, tlr_fifo, tlr_back and tlr_emit.
module thick_line_rasterizer_top import tlr_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int MAX_THICKNESS = MAX_THICKNESS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [STRIDE_W-1:0]   cfg_line_stride,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic signed [IN_COORD_W-1:0] in_start_x,
  input  logic signed [IN_COORD_W-1:0] in_start_y,
  input  logic signed [IN_COORD_W-1:0] in_end_x,
  input  logic signed [IN_COORD_W-1:0] in_end_y,
  input  logic        [COLOUR_W-1:0]   in_red,
  input  logic        [COLOUR_W-1:0]   in_green,
  input  logic        [COLOUR_W-1:0]   in_blue,
  input  logic        [THICK_IN_W-1:0] in_thickness,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic signed [OFFSET_W-1:0]   out_byte_offset,
  output logic        [COLOUR_W-1:0]   out_red,
  output logic        [COLOUR_W-1:0]   out_green,
  output logic        [COLOUR_W-1:0]   out_blue,
  output logic                         out_last_pixel
);

  line_cmd_t                    front_cmd;
  line_cmd_t                    q_data;
  logic [$bits(line_cmd_t)-1:0] q_raw;
  logic                         q_full;
  logic                         q_empty;
  logic                         q_pop;
  logic                         p_ready;
  logic                         p_valid;
  logic signed [COORD_BITS-1:0] p_x;
  logic signed [COORD_BITS-1:0] p_y;
  logic        [COLOUR_W-1:0]   p_red;
  logic        [COLOUR_W-1:0]   p_green;
  logic        [COLOUR_W-1:0]   p_blue;
  logic                         p_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_data    = line_cmd_t'(q_raw);

  tlr_front u_front (
    .in_command   (in_command),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_thickness (in_thickness),
    .cmd_o        (front_cmd)
  );

  tlr_fifo #(
    .WIDTH ($bits(line_cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .pop       (q_pop),
    .pop_data  (q_raw),
    .full      (q_full),
    .empty     (q_empty)
  );

  tlr_back #(
    .COORD_BITS    (COORD_BITS),
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .p_ready (p_ready),
    .p_valid (p_valid),
    .p_x     (p_x),
    .p_y     (p_y),
    .p_red   (p_red),
    .p_green (p_green),
    .p_blue  (p_blue),
    .p_last  (p_last)
  );

  tlr_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_line_stride (cfg_line_stride),
    .p_valid         (p_valid),
    .p_x             (p_x),
    .p_y             (p_y),
    .p_red           (p_red),
    .p_green         (p_green),
    .p_blue          (p_blue),
    .p_last          (p_last),
    .p_ready         (p_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_byte_offset (out_byte_offset),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

// ----- rtl/tlr_checker.sv -----
// Port-level checks for the thick line rasterizer, bound to the top level.
// Sees only the top-level ports. Uses tlr_pkg.
module tlr_checker import tlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] out_pixel_x,
  input logic signed [COORD_BITS-1:0] out_pixel_y,
  input logic signed [OFFSET_W-1:0]   out_byte_offset,
  input logic                         out_last_pixel
);

  // Reset empties the queue and the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output beat or input stall present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_byte_offset) && $stable(out_last_pixel))
    else $error("stalled output beat changed");

  // The queue can only fill up while the output side is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall && out_valid && out_stall))
    else $error("input stall rose without a taken beat and a stalled output");

endmodule

bind thick_line_rasterizer_top tlr_checker #(
  .COORD_BITS (COORD_BITS)
) u_tlr_checker (.*);
